// File: src/bbfp_pkg.sv
// Package for the bounding box block: widths, beat types and box record.
// Used by every module under src; depends on nothing else.
package bbfp_pkg;

  localparam int COORD_BITS = 32;
  localparam int FIELD_W    = 32;
  localparam int NUM_AXES   = 3;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
  // Sum of three squared half extents, each below 2^(2*COORD_BITS-2) + 1.
  localparam int SUM_W      = 2 * COORD_BITS + 2;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int ITER_W     = $clog2(ROOT_W + 1);
  localparam int SQ_W       = 2 * COORD_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        ucoord_t;
  typedef coord_t  [NUM_AXES-1:0]       coord3_t;
  typedef ucoord_t [NUM_AXES-1:0]       ucoord3_t;

  typedef struct packed {
    logic                       has_point;
    logic signed [FIELD_W-1:0]  coord_x;
    logic signed [FIELD_W-1:0]  coord_y;
    logic signed [FIELD_W-1:0]  coord_z;
    logic                       last_point;
  } in_beat_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0]  center_x;
    logic signed [FIELD_W-1:0]  center_y;
    logic signed [FIELD_W-1:0]  center_z;
    logic [FIELD_W-1:0]         half_x;
    logic [FIELD_W-1:0]         half_y;
    logic [FIELD_W-1:0]         half_z;
    logic [FIELD_W-1:0]         radius;
  } out_beat_t;

  // Finished extents of one group, passed from the front to the back.
  typedef struct packed {
    coord3_t mn;
    coord3_t mx;
  } box_t;

endpackage

// File: src/bbfp_front.sv
// Front end: accepts point beats and keeps running per-axis minima and maxima.
// Pushes one box record per group into the queue. Depends on bbfp_pkg.
module bbfp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bbfp_pkg::in_beat_t in_data,
  output logic              push,
  input  logic              q_full,
  output bbfp_pkg::box_t    push_box
);
  import bbfp_pkg::*;

  logic    seen_r, seen_nxt;
  box_t    box_r, box_nxt;
  box_t    upd;
  coord3_t pt;
  logic    accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pt[0] = coord_t'(in_data.coord_x[COORD_BITS-1:0]);
    pt[1] = coord_t'(in_data.coord_y[COORD_BITS-1:0]);
    pt[2] = coord_t'(in_data.coord_z[COORD_BITS-1:0]);
    upd = box_r;
    if (in_data.has_point) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        if (!seen_r || ($signed(pt[i]) < $signed(box_r.mn[i]))) upd.mn[i] = pt[i];
        if (!seen_r || ($signed(pt[i]) > $signed(box_r.mx[i]))) upd.mx[i] = pt[i];
      end
    end
  end

  assign push     = accept && in_data.last_point;
  assign push_box = upd;

  always_comb begin
    seen_nxt = seen_r;
    box_nxt  = box_r;
    if (accept) begin
      if (in_data.last_point) begin
        seen_nxt = 1'b0;
        box_nxt  = '0;
      end else begin
        seen_nxt = seen_r || in_data.has_point;
        box_nxt  = upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      box_r  <= '0;
    end else begin
      seen_r <= seen_nxt;
      box_r  <= box_nxt;
    end
  end

  // An empty group must leave the extents at zero so that the back end gives zeros.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r |-> (box_r == '0))
    else $error("extents not cleared while no point seen");

  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> (($signed(box_r.mn[0]) <= $signed(box_r.mx[0])) &&
                ($signed(box_r.mn[1]) <= $signed(box_r.mx[1])) &&
                ($signed(box_r.mn[2]) <= $signed(box_r.mx[2]))))
    else $error("minimum above maximum");

endmodule

// File: src/bbfp_queue.sv
// Short register queue of box records between the front and the back end.
// Depends on bbfp_pkg.
module bbfp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bbfp_pkg::box_t push_box,
  output logic           full,
  output logic           pop_valid,
  input  logic           pop_ready,
  output bbfp_pkg::box_t pop_box
);
  import bbfp_pkg::*;

  box_t                 mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_r, rd_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic                 pop;

  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_box   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_box;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("box pushed into a full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count out of range");

endmodule

// File: src/bbfp_isqrt.sv
// Bit-serial floor square root, one result bit per cycle.
// Depends on bbfp_pkg.
module bbfp_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bbfp_pkg::SUM_W-1:0] radicand,
  output logic                      busy,
  output logic [bbfp_pkg::ROOT_W-1:0] root
);
  import bbfp_pkg::*;

  logic [SUM_W-1:0]  n_r;
  logic [REM_W-1:0]  rem_r, rem_sh, trial;
  logic [ROOT_W-1:0] root_r;
  logic [ITER_W-1:0] cnt_r;
  logic              busy_r;
  logic              fits;

  // Bring down the next two radicand bits and try the next root bit as one.
  assign rem_sh = {rem_r[REM_W-3:0], n_r[SUM_W-1:SUM_W-2]};
  assign trial  = REM_W'({root_r, 2'b01});
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      n_r    <= {n_r[SUM_W-3:0], 2'b00};
      rem_r  <= fits ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= ITER_W'(ROOT_W);
    end else if (busy_r) begin
      busy_r <= (cnt_r != ITER_W'(1));
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign busy = busy_r;
  assign root = root_r;

  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0))
    else $error("root unit busy with no step left");

endmodule

// File: src/bbfp_back.sv
// Back end: takes a box record, forms centre and half extents, sums the squares
// on one shared multiplier and runs the square root. Depends on bbfp_pkg, bbfp_isqrt.
module bbfp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  bbfp_pkg::box_t      pop_box,
  output logic                out_valid,
  input  logic                out_ready,
  output bbfp_pkg::out_beat_t out_data
);
  import bbfp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CEN  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  box_t              box_r;
  coord3_t           cen_r;
  ucoord3_t          half_r;
  logic [SQ_W-1:0]   prod_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_c;
  out_beat_t         out_r;
  logic              out_valid_r, out_valid_nxt;
  coord3_t           cen_c;
  ucoord3_t          half_c;
  ucoord_t           mul_op;
  logic              sq_start, sq_busy, load_out;
  logic [ROOT_W-1:0] sq_root;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      logic signed [COORD_BITS:0] s, d;
      s = {box_r.mn[i][COORD_BITS-1], box_r.mn[i]}
        + {box_r.mx[i][COORD_BITS-1], box_r.mx[i]};
      cen_c[i] = s[COORD_BITS:1];
      d = {box_r.mx[i][COORD_BITS-1], box_r.mx[i]}
        - {cen_c[i][COORD_BITS-1], cen_c[i]};
      half_c[i] = d[COORD_BITS-1:0];
    end
  end

  always_comb begin
    case (cnt_r)
      2'd0:    mul_op = half_r[0];
      2'd1:    mul_op = half_r[1];
      2'd2:    mul_op = half_r[2];
      default: mul_op = '0;
    endcase
  end

  assign pop_ready = (state_r == S_IDLE);
  assign sq_start  = (state_r == S_MUL) && (cnt_r == 2'd3);
  assign load_out  = (state_r == S_SQRT) && !sq_busy && (!out_valid_r || out_ready);

  // The last square is still in prod_r when the root starts, so it joins the sum here.
  assign sum_c = sum_r + SUM_W'(prod_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: if (pop_valid) state_nxt = S_CEN;
      S_CEN: begin
        state_nxt = S_MUL;
        cnt_nxt   = '0;
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 2'd3) state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (load_out) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The product of one step is added in the next, so the sum lags behind prod_r.
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) box_r <= pop_box;
    if (state_r == S_CEN) begin
      cen_r  <= cen_c;
      half_r <= half_c;
      sum_r  <= '0;
      prod_r <= '0;
    end
    if (state_r == S_MUL) begin
      prod_r <= mul_op * mul_op;
      sum_r  <= sum_c;
    end
    if (load_out) begin
      out_r.center_x <= FIELD_W'($signed(cen_r[0]));
      out_r.center_y <= FIELD_W'($signed(cen_r[1]));
      out_r.center_z <= FIELD_W'($signed(cen_r[2]));
      out_r.half_x   <= FIELD_W'(half_r[0]);
      out_r.half_y   <= FIELD_W'(half_r[1]);
      out_r.half_z   <= FIELD_W'(half_r[2]);
      out_r.radius   <= FIELD_W'(sq_root);
    end
  end

  bbfp_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sum_c),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_root_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !sq_busy)
    else $error("root unit running with no box in hand");

  a_start_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |=> sq_busy)
    else $error("root unit did not start");

endmodule

// File: src/bounding_box_from_points_top.sv
// Each result comes from the bit-serial square root, run once the beat that closes
// its group has been taken; the back end takes no new box until that result is out.
// Throughput: one point beat per cycle while the queue is not full; a two-entry
// queue of finished boxes lies between front and back.
// Reset (rst_n low, synchronous) empties the queue and clears the front end's extents.
module bounding_box_from_points_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bbfp_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bbfp_pkg::out_beat_t out_data
);
  import bbfp_pkg::*;

  logic push, q_full, pop_valid, pop_ready;
  box_t push_box, pop_box;

  bbfp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push),
    .q_full   (q_full),
    .push_box (push_box)
  );

  bbfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_box  (push_box),
    .full      (q_full),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_box   (pop_box)
  );

  bbfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_box   (pop_box),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: verif/tb.sv
// Self-checking testbench for bounding_box_from_points_top: point beats in, box beats out.
// Predicts each box from its own running extents, or takes a hand-written one, and compares each field on arrival.
// Depends on bbfp_pkg and the top level under src.
`timescale 1ns / 1ps

module tb;
  import bbfp_pkg::*;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  typedef struct packed {
    in_beat_t  b;
    logic      typed;
    out_beat_t want;
  } row_t;

  // Running extents of the group in progress, as the block should hold them.
  logic      bx_seen = 1'b0;
  coord_t    bx_lo[NUM_AXES];
  coord_t    bx_hi[NUM_AXES];
  out_beat_t boxes_due[$];
  int        fails = 0;
  bit        calm  = 1'b0;

  bounding_box_from_points_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

  // Largest r with r*r <= n, built one bit at a time from the top.
  function automatic logic [31:0] floor_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned cand;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if (cand * cand <= n) root = cand;
    end
    return root[31:0];
  endfunction

  function automatic bit box_step(input in_beat_t b, output out_beat_t r);
    coord_t                p[NUM_AXES];
    coord_t                mid[NUM_AXES];
    logic [31:0]           ext[NUM_AXES];
    logic signed [32:0]    span_sum;
    longint unsigned       sq;
    p[0] = b.coord_x;
    p[1] = b.coord_y;
    p[2] = b.coord_z;
    r = '0;
    if (b.has_point) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (!bx_seen || p[a] < bx_lo[a]) bx_lo[a] = p[a];
        if (!bx_seen || p[a] > bx_hi[a]) bx_hi[a] = p[a];
      end
      bx_seen = 1'b1;
    end
    if (!b.last_point) return 1'b0;
    if (bx_seen) begin
      sq = 0;
      for (int a = 0; a < NUM_AXES; a++) begin
        // The 33-bit sum keeps the carry; an arithmetic shift gives the floor.
        span_sum = {bx_lo[a][COORD_BITS-1], bx_lo[a]} + {bx_hi[a][COORD_BITS-1], bx_hi[a]};
        mid[a]   = coord_t'(span_sum >>> 1);
        ext[a]   = bx_hi[a] - mid[a];
        sq       = sq + longint'(ext[a]) * longint'(ext[a]);
      end
      r.center_x = mid[0];
      r.center_y = mid[1];
      r.center_z = mid[2];
      r.half_x   = ext[0];
      r.half_y   = ext[1];
      r.half_z   = ext[2];
      r.radius   = floor_sqrt(sq);
    end
    bx_seen = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      bx_lo[a] = '0;
      bx_hi[a] = '0;
    end
    return 1'b1;
  endfunction

  function automatic in_beat_t beat(input logic has, input logic [31:0] x, y, z,
                                    input logic last);
    in_beat_t b;
    b.has_point  = has;
    b.coord_x    = x;
    b.coord_y    = y;
    b.coord_z    = z;
    b.last_point = last;
    return b;
  endfunction

  function automatic out_beat_t box_out(input logic [31:0] cx, cy, cz, hx, hy, hz, r);
    out_beat_t o;
    o.center_x = cx;
    o.center_y = cy;
    o.center_z = cz;
    o.half_x   = hx;
    o.half_y   = hy;
    o.half_z   = hz;
    o.radius   = r;
    return o;
  endfunction

  // Mostly points near the group's anchor, with extremes and wide values mixed in.
  function automatic logic [31:0] pick_coord(input logic [31:0] anchor);
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom;
      3:       return $urandom_range(0, 2000) - 32'd1000;
      default: return anchor + $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
    endcase
  endfunction

  // Valid stays high across back-to-back beats; it drops only when a gap is drawn.
  task automatic send_beat(input in_beat_t b, input logic typed, input out_beat_t want);
    int        gap;
    out_beat_t box;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    if (box_step(b, box)) boxes_due.push_back(typed ? want : box);
  endtask

  task automatic note_fail(input string what, input logic [31:0] want, input logic [31:0] got);
    fails++;
    if (fails <= 10) $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  always @(posedge clk) begin : check_boxes
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (boxes_due.size() == 0) begin
        fails++;
        if (fails <= 10) $display("box beat with none expected: %h", out_data);
      end else begin
        want = boxes_due.pop_front();
        if (out_data.center_x !== want.center_x)
          note_fail("center_x", want.center_x, out_data.center_x);
        if (out_data.center_y !== want.center_y)
          note_fail("center_y", want.center_y, out_data.center_y);
        if (out_data.center_z !== want.center_z)
          note_fail("center_z", want.center_z, out_data.center_z);
        if (out_data.half_x !== want.half_x) note_fail("half_x", want.half_x, out_data.half_x);
        if (out_data.half_y !== want.half_y) note_fail("half_y", want.half_y, out_data.half_y);
        if (out_data.half_z !== want.half_z) note_fail("half_z", want.half_z, out_data.half_z);
        if (out_data.radius !== want.radius) note_fail("radius", want.radius, out_data.radius);
      end
    end
  end

  // Result side: a fresh stall is drawn before each box beat.
  initial begin : sink
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin : stimulus
    row_t        plan[$];
    out_beat_t   none;
    out_beat_t   zero_box;
    logic [31:0] anchor;
    int          fed;
    int          span;
    bit          closer;

    none     = '0;
    zero_box = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      bx_lo[a] = '0;
      bx_hi[a] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Empty group straight after reset, then single-point groups at zero and at the extremes.
    plan.push_back({beat(1'b0, 32'h0, 32'h0, 32'h0, 1'b1), 1'b1, zero_box});
    plan.push_back({beat(1'b1, 32'h0, 32'h0, 32'h0, 1'b1), 1'b1, zero_box});
    plan.push_back({beat(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1), 1'b1,
                    box_out(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0)});
    plan.push_back({beat(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1), 1'b1,
                    box_out(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0)});
    // Full-range box, with an idle beat in the middle of it.
    plan.push_back({beat(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0), 1'b0, none});
    plan.push_back({beat(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0), 1'b0, none});
    plan.push_back({beat(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1), 1'b0, none});
    // Separate end marker after a point; its own coordinates must be ignored.
    plan.push_back({beat(1'b1, 32'd1, 32'd2, 32'd3, 1'b0), 1'b0, none});
    plan.push_back({beat(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001, 1'b1), 1'b1,
                    box_out(32'd1, 32'd2, 32'd3, 0, 0, 0, 0)});
    // Odd negative sums, where the centre must round towards minus infinity.
    plan.push_back({beat(1'b1, 32'hFFFF_FFFD, 32'h0, 32'h0001_0000, 1'b0), 1'b0, none});
    plan.push_back({beat(1'b1, 32'h0, 32'hFFFF_FFFD, 32'hFFFF_0000, 1'b0), 1'b0, none});
    plan.push_back({beat(1'b1, 32'd5, 32'd5, 32'd5, 1'b1), 1'b0, none});
    plan.push_back({beat(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0), 1'b0, none});
    plan.push_back({beat(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1), 1'b0, none});
    plan.push_back({beat(1'b0, 32'h1234_5678, 32'h0, 32'h0, 1'b1), 1'b1, zero_box});
    plan.push_back({beat(1'b1, 32'h0001_0000, 32'h0003_0000, 32'hFFFF_0000, 1'b0), 1'b0, none});
    plan.push_back({beat(1'b1, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 1'b1), 1'b0, none});
    plan.push_back({beat(1'b0, 32'h0, 32'h0, 32'h0, 1'b0), 1'b0, none});
    plan.push_back({beat(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0), 1'b0, none});
    plan.push_back({beat(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1), 1'b0, none});

    foreach (plan[i]) send_beat(plan[i].b, plan[i].typed, plan[i].want);

    fed = 0;
    while (fed < 900) begin
      if ($urandom_range(0, 24) == 0) calm = !calm;
      case ($urandom_range(0, 19))
        0: send_beat(beat(1'b0, $urandom, $urandom, $urandom, 1'b0), 1'b0, none);
        1: begin
          send_beat(beat(1'b0, $urandom, $urandom, $urandom, 1'b1), 1'b0, none);
          fed++;
        end
        default: begin
          span   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 5);
          anchor = $urandom;
          closer = ($urandom_range(0, 5) == 0);
          for (int k = 0; k < span; k++) begin
            if ($urandom_range(0, 9) == 0)
              send_beat(beat(1'b0, $urandom, $urandom, $urandom, 1'b0), 1'b0, none);
            send_beat(beat(1'b1, pick_coord(anchor), pick_coord(anchor), pick_coord(anchor),
                           (k == span - 1) && !closer), 1'b0, none);
            fed++;
          end
          if (closer) begin
            send_beat(beat(1'b0, $urandom, $urandom, $urandom, 1'b1), 1'b0, none);
            fed++;
          end
        end
      endcase
    end
    in_valid <= 1'b0;

    while (boxes_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fails == 0 && boxes_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
